// ===== rtl/ring_buffer_deque_macros.svh =====
// Assertion macros used by the deque top level.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define RBD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rbd_pkg.sv =====
// Types and constants of the ring buffer deque.
package rbd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Register index 0: capacity, selected by paddr bit 2.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Result of one operation, minus the popped word.
  typedef struct packed {
    logic             rd_pop;
    status_e          status;
    logic [CAP_W-1:0] count;
  } op_info_t;

  // Deque state seen by the top level.
  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic [CAP_W-1:0] cap_use;
    logic [CAP_W-1:0] count;
  } dq_status_t;

endpackage

// ===== rtl/rbd_chan_if.sv =====
// Valid/ready channel interfaces for operations and results.
interface rbd_cmd_if;
  import rbd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface rbd_rsp_if;
  import rbd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [1:0]               status;
  logic [CAP_W-1:0]         count;
  logic                     empty;

  modport source (output valid, output read_value, output status, output count,
                  output empty, input ready);
  modport sink (input valid, input read_value, input status, input count,
                input empty, output ready);
endinterface

// ===== rtl/rbd_ram.sv =====
// Generic single-port RAM with registered read data.
module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rbd_ctrl.sv =====
// Head index, count and capacity of the deque; RAM address generation.
module rbd_ctrl #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [1:0]                opcode_i,
  input  logic                      cfg_we_i,
  input  logic [rbd_pkg::CAP_W-1:0] cfg_data_i,
  output logic                      mem_we_o,
  output logic                      mem_re_o,
  output logic [AW-1:0]             mem_addr_o,
  output rbd_pkg::op_info_t         info_o,
  output rbd_pkg::dq_status_t       status_o
);
  import rbd_pkg::*;

  // wide enough for head + count and for DEPTH itself
  localparam int unsigned SW = ((AW > CAP_W) ? AW : CAP_W) + 1;
  localparam logic [SW-1:0] DEPTH_W = SW'(DEPTH);

  logic [CAP_W-1:0] capacity_q, capacity_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CAP_W-1:0] count_q, count_d;

  logic [SW-1:0] cap_w, head_w, cnt_w;
  logic [SW-1:0] offset, back_sum, back_idx, head_inc_sum, head_inc, head_dec;
  logic          full, empty, take_back;
  op_info_t      info;
  logic          we, re;
  logic [SW-1:0] addr_w;

  // capacity saturated to 1..DEPTH
  always_comb begin
    cap_w = SW'(capacity_q);
    if (capacity_q == '0) begin
      cap_w = SW'(1);
    end else if (cap_w > DEPTH_W) begin
      cap_w = DEPTH_W;
    end
  end

  assign head_w    = SW'(head_q);
  assign cnt_w     = SW'(count_q);
  assign full      = (cnt_w >= cap_w);
  assign empty     = (count_q == '0);
  assign take_back = (opcode_e'(opcode_i) == OP_POP_BACK);

  // back slot: head + count for a push, head + count - 1 for a pop
  assign offset   = take_back ? (cnt_w - SW'(1)) : cnt_w;
  assign back_sum = head_w + offset;
  assign back_idx = (back_sum >= cap_w) ? (back_sum - cap_w) : back_sum;

  assign head_inc_sum = head_w + SW'(1);
  assign head_inc     = (head_inc_sum >= cap_w) ? (head_inc_sum - cap_w) : head_inc_sum;
  assign head_dec     = (head_q == '0) ? (cap_w - SW'(1)) : (head_w - SW'(1));

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    capacity_d  = capacity_q;
    we          = 1'b0;
    re          = 1'b0;
    addr_w      = head_w;
    info.rd_pop = 1'b0;
    info.status = ST_OK;
    case (opcode_e'(opcode_i))
      OP_PUSH_FRONT: begin
        if (full) begin
          info.status = ST_FULL;
        end else begin
          we      = 1'b1;
          addr_w  = head_dec;
          head_d  = head_dec[AW-1:0];
          count_d = count_q + CAP_W'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          info.status = ST_FULL;
        end else begin
          we      = 1'b1;
          addr_w  = back_idx;
          count_d = count_q + CAP_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          info.status = ST_EMPTY;
        end else begin
          re          = 1'b1;
          info.rd_pop = 1'b1;
          addr_w      = head_w;
          head_d      = head_inc[AW-1:0];
          count_d     = count_q - CAP_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          info.status = ST_EMPTY;
        end else begin
          re          = 1'b1;
          info.rd_pop = 1'b1;
          addr_w      = back_idx;
          count_d     = count_q - CAP_W'(1);
        end
      end
      default: begin
        info.status = ST_OK;
      end
    endcase
    info.count = count_d;
    if (!accept_i) begin
      head_d  = head_q;
      count_d = count_q;
    end
    // capacity only changes while empty; head restarts at slot 0
    if (cfg_we_i && empty) begin
      capacity_d = cfg_data_i;
      head_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
      head_q     <= '0;
      count_q    <= '0;
    end else begin
      capacity_q <= capacity_d;
      head_q     <= head_d;
      count_q    <= count_d;
    end
  end

  assign mem_we_o   = accept_i & we;
  assign mem_re_o   = accept_i & re;
  assign mem_addr_o = addr_w[AW-1:0];
  assign info_o     = info;

  assign status_o.capacity = capacity_q;
  assign status_o.cap_use  = cap_w[CAP_W-1:0];
  assign status_o.count    = count_q;

endmodule

// ===== rtl/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: channels, register port, result stage.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   cmd     | in        | valid/ready        | opcode, value
//   rsp     | out       | valid/ready        | read_value, status, count, empty
//   apb     | in        | psel/penable/pwrite| capacity register at byte 0
//
// One operation per cycle sustained while rsp is ready; a cmd transfer is registered
// in stage 1 (registered read of the storage RAM) and then in the result register,
// which drives rsp valid.
// Head and count update at the cmd transfer, so the next operation sees them at once.
// A stalled rsp holds the result register; one more operation may wait behind it.
// Reset clears head, count, capacity (to 16) and the valid flags; storage is not cleared.
`include "ring_buffer_deque_macros.svh"

module ring_buffer_deque #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rbd_cmd_if.sink                    cmd,
  rbd_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbd_pkg::ADDR_W-1:0] paddr,
  input  logic [rbd_pkg::DATA_W-1:0] pwdata,
  output logic [rbd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import rbd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              accept;
  logic              cfg_we;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_rdata;
  op_info_t          info;
  dq_status_t        st;

  // stage 1: operation issued, RAM read in flight
  logic     s1_valid_q;
  op_info_t s1_info_q;

  // stage 2: result register
  logic              out_valid_q;
  logic [WORD_W-1:0] out_value_q;
  op_info_t          out_info_q;

  logic load;

  // assertion helpers
  logic full_push;
  logic rsp_stall;

  // APB: write at the access phase; pready is tied high
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(st.capacity) : '0;

  // result register frees when empty or taken this cycle
  assign load      = s1_valid_q & (~out_valid_q | rsp.ready);
  assign cmd.ready = ~s1_valid_q | load;
  assign accept    = cmd.valid & cmd.ready;

  rbd_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .opcode_i  (cmd.opcode),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(pwdata[CAP_W-1:0]),
    .mem_we_o  (mem_we),
    .mem_re_o  (mem_re),
    .mem_addr_o(mem_addr),
    .info_o    (info),
    .status_o  (st)
  );

  // read data holds while stage 1 stalls, since no new read is issued then
  rbd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(cmd.value),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (load) begin
        s1_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= info;
    end
    if (load) begin
      out_info_q  <= s1_info_q;
      out_value_q <= s1_info_q.rd_pop ? mem_rdata : '0;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.read_value = out_value_q;
  assign rsp.status     = out_info_q.status;
  assign rsp.count      = out_info_q.count;
  assign rsp.empty      = (out_info_q.count == '0);

  assign full_push = accept & (opcode_e'(cmd.opcode) inside {OP_PUSH_FRONT, OP_PUSH_BACK})
                     & (st.count == st.cap_use);
  assign rsp_stall = out_valid_q & ~rsp.ready;

  // stored words never exceed the capacity in use
  `RBD_ASSERT_ALWAYS(a_count_le_cap, st.count <= st.cap_use, "count above capacity")
  // a push into a full deque leaves the count alone
  `RBD_ASSERT_NEXT(a_full_push_hold, full_push, st.count == $past(st.count), "full push moved count")
  // an issued operation stays in stage 1 while the result register is stalled
  `RBD_ASSERT_NEXT(a_s1_hold, s1_valid_q && rsp_stall, s1_valid_q && out_valid_q, "stalled op lost")

endmodule
